// File: design/acn_pkg.sv
// ----------------------------------------------------------------------------
// acn_pkg
// Shared types and constants of the audio chunk timestamp normalizer.
// ----------------------------------------------------------------------------
package acn_pkg;

    // Width of the frame count carried from the front to the back part.
    localparam int FRAMES_W = 32;

    // Nanoseconds per second, the conversion factor of the time base.
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    // Largest whole-second count whose product with NS_PER_SEC fits 63 bits.
    localparam logic [63:0] Q_MAX = 64'd9223372036;

    // Saturation value of the non-monotonic step counter.
    localparam logic [31:0] STEP_MAX = 32'hFFFF_FFFF;

    // Register reset values.
    localparam logic [19:0] RATE_RESET = 20'd48000;
    localparam logic [1:0]  CHAN_RESET = 2'd2;

    // Configuration register indexes.
    localparam logic REG_SAMPLE_RATE   = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

    // Error codes.
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_NEG   = 2'd1;
    localparam logic [1:0] ERR_COUNT = 2'd2;
    localparam logic [1:0] ERR_OVF   = 2'd3;

    // Packed result width on the master side, rounded up to whole bytes.
    localparam int OUT_W = 352;

    // A classified chunk waiting in the queue.
    typedef struct packed {
        logic                first;
        logic [63:0]         ts;
        logic [FRAMES_W-1:0] frames;
        logic [1:0]          code;
    } q_entry_t;

    // One result item.
    typedef struct packed {
        logic [62:0] total;
        logic [62:0] max_res;
        logic [62:0] max_back;
        logic [31:0] steps;
        logic [63:0] resid;
        logic [62:0] norm;
        logic [1:0]  code;
    } result_t;

    // Back part sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_Q,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_R,
        ST_START_F,
        ST_DIV_F,
        ST_SUM,
        ST_EXPECT,
        ST_FINISH
    } back_state_t;

endpackage

// File: design/acn_front.sv
// ----------------------------------------------------------------------------
// acn_front
// Classifies an incoming chunk: sign check, count check and frame count.
// ----------------------------------------------------------------------------
module acn_front #(
    parameter int CHUNK_COUNT_BITS = 20
) (
    input  logic                        first_chunk,
    input  logic [63:0]                 chunk_timestamp_ns,
    input  logic [CHUNK_COUNT_BITS-1:0] interleaved_count,
    input  logic [1:0]                  channel_count,
    output acn_pkg::q_entry_t           entry
);

    logic chan_ok;
    logic count_bad;

    // A chunk must be non-empty and hold whole frames of a valid layout.
    always_comb
    begin
        chan_ok   = (channel_count == 2'd1) || (channel_count == 2'd2);
        count_bad = (interleaved_count == '0) || !chan_ok ||
                    ((channel_count == 2'd2) && interleaved_count[0]);
    end

    // Build the queue entry; the sign check takes precedence.
    always_comb
    begin
        entry.first = first_chunk;
        entry.ts    = chunk_timestamp_ns;
        if (channel_count == 2'd2)
        begin
            entry.frames = acn_pkg::FRAMES_W'(interleaved_count >> 1);
        end
        else
        begin
            entry.frames = acn_pkg::FRAMES_W'(interleaved_count);
        end
        if (chunk_timestamp_ns[63])
        begin
            entry.code = acn_pkg::ERR_NEG;
        end
        else if (count_bad)
        begin
            entry.code = acn_pkg::ERR_COUNT;
        end
        else
        begin
            entry.code = acn_pkg::ERR_OK;
        end
    end

endmodule

// File: design/acn_fifo.sv
// ----------------------------------------------------------------------------
// acn_fifo
// Two-entry queue between the front and the back part.
// ----------------------------------------------------------------------------
module acn_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  acn_pkg::q_entry_t push_data,
    input  logic              pop,
    output acn_pkg::q_entry_t head,
    output logic              full,
    output logic              empty
);

    acn_pkg::q_entry_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

    // Storage is written only on a push.
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: design/acn_div.sv
// ----------------------------------------------------------------------------
// acn_div
// Bit-serial restoring divider: 64-bit dividend by a 20-bit divisor.
// ----------------------------------------------------------------------------
module acn_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [19:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [19:0] remainder
);

    logic [63:0] quo_reg;
    logic [19:0] rem_reg;
    logic [19:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [20:0] shifted;
    logic        fits;

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

    // One quotient bit per cycle.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[63]};
        fits    = (shifted >= {1'b0, dvs_reg});
    end

    // Data path of the shift and subtract loop.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[62:0], fits};
            if (fits)
            begin
                rem_reg <= 20'(shifted - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= shifted[19:0];
            end
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= 6'd63;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: design/acn_back.sv
// ----------------------------------------------------------------------------
// acn_back
// Sequencer that converts samples to time, checks overflow, keeps the
// stream state and diagnostics, and holds the result register.
// ----------------------------------------------------------------------------
module acn_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [19:0]       rate_cfg,
    input  acn_pkg::q_entry_t head,
    input  logic              empty,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_ready,
    output acn_pkg::result_t  res
);

    acn_pkg::back_state_t state_reg;
    acn_pkg::back_state_t state_next;

    // Stream state.
    logic [62:0] anchor_reg;
    logic [62:0] prev_reg;
    logic        have_prev_reg;
    logic [62:0] cum_reg;
    logic [31:0] steps_reg;
    logic [62:0] back_reg;
    logic [62:0] wres_reg;
    logic [1:0]  err_reg;

    // Per-chunk working registers.
    acn_pkg::q_entry_t ent_reg;
    logic        first_reg;
    logic [1:0]  code_reg;
    logic [46:0] plo_reg;
    logic [46:0] phi_reg;
    logic [50:0] rf_reg;
    logic [63:0] whole_reg;
    logic [63:0] offset_reg;
    logic [62:0] exp_reg;
    logic [62:0] newcum_reg;

    logic              out_valid_reg;
    acn_pkg::result_t  out_reg;

    // Divider hookup.
    logic        div_start;
    logic [63:0] div_dividend;
    logic        div_done;
    logic [63:0] div_quo;
    logic [19:0] div_rem;

    // Combinational helpers.
    logic [19:0] rate_eff;
    logic        avail;
    logic        eff_first;
    logic        sticky;
    logic        q_over;
    logic [63:0] offset_sum;
    logic [62:0] base;
    logic [63:0] exp_sum;
    logic [63:0] cum_sum;
    logic        exp_ovf;
    logic [62:0] ts63;
    logic [62:0] back_diff;
    logic [31:0] steps_new;
    logic [62:0] back_new;
    logic [62:0] abs_res;
    logic [62:0] wres_new;

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    acn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (rate_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Classification of the queue head and the arithmetic of each step.
    always_comb
    begin
        rate_eff   = (rate_cfg == '0) ? 20'd1 : rate_cfg;
        avail      = !empty && !out_valid_reg;
        eff_first  = head.first || !have_prev_reg;
        sticky     = !head.first && (err_reg != acn_pkg::ERR_OK);
        q_over     = (div_quo > acn_pkg::Q_MAX);
        offset_sum = whole_reg + 64'(div_quo[30:0]);
        base       = first_reg ? ent_reg.ts[62:0] : anchor_reg;
        exp_sum    = 64'(base) + offset_reg;
        cum_sum    = 64'(cum_reg) + 64'(ent_reg.frames);
        exp_ovf    = exp_sum[63] || cum_sum[63];
    end

    // Diagnostics for a good chunk.
    always_comb
    begin
        ts63      = ent_reg.ts[62:0];
        back_diff = prev_reg - ts63;
        steps_new = steps_reg;
        back_new  = back_reg;
        if (!first_reg)
        begin
            if ((ts63 <= prev_reg) && (steps_reg != acn_pkg::STEP_MAX))
            begin
                steps_new = steps_reg + 32'd1;
            end
            if ((ts63 < prev_reg) && (back_diff > back_reg))
            begin
                back_new = back_diff;
            end
        end
        abs_res  = (ts63 >= exp_reg) ? (ts63 - exp_reg) : (exp_reg - ts63);
        wres_new = (abs_res > wres_reg) ? abs_res : wres_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            acn_pkg::ST_IDLE:
            begin
                if (avail && !sticky && (head.code == acn_pkg::ERR_OK))
                begin
                    state_next = acn_pkg::ST_DIV_Q;
                end
            end
            acn_pkg::ST_DIV_Q:
            begin
                if (div_done)
                begin
                    state_next = q_over ? acn_pkg::ST_FINISH : acn_pkg::ST_MUL_LO;
                end
            end
            acn_pkg::ST_MUL_LO:  state_next = acn_pkg::ST_MUL_HI;
            acn_pkg::ST_MUL_HI:  state_next = acn_pkg::ST_MUL_R;
            acn_pkg::ST_MUL_R:   state_next = acn_pkg::ST_START_F;
            acn_pkg::ST_START_F: state_next = acn_pkg::ST_DIV_F;
            acn_pkg::ST_DIV_F:
            begin
                if (div_done)
                begin
                    state_next = acn_pkg::ST_SUM;
                end
            end
            acn_pkg::ST_SUM:
            begin
                state_next = offset_sum[63] ? acn_pkg::ST_FINISH : acn_pkg::ST_EXPECT;
            end
            acn_pkg::ST_EXPECT:  state_next = acn_pkg::ST_FINISH;
            acn_pkg::ST_FINISH:  state_next = acn_pkg::ST_IDLE;
            default:             state_next = acn_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        pop          = 1'b0;
        div_start    = 1'b0;
        div_dividend = 64'(rf_reg);
        case (state_reg)
            acn_pkg::ST_IDLE:
            begin
                pop          = avail;
                div_start    = avail && !sticky && (head.code == acn_pkg::ERR_OK);
                div_dividend = eff_first ? 64'd0 : 64'(cum_reg);
            end
            acn_pkg::ST_START_F:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                pop       = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acn_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers of the conversion.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            acn_pkg::ST_IDLE:
            begin
                if (avail)
                begin
                    ent_reg   <= head;
                    first_reg <= eff_first;
                end
            end
            acn_pkg::ST_MUL_LO:
            begin
                plo_reg <= 47'(div_quo[16:0]) * 47'(acn_pkg::NS_PER_SEC);
            end
            acn_pkg::ST_MUL_HI:
            begin
                phi_reg <= 47'(div_quo[33:17]) * 47'(acn_pkg::NS_PER_SEC);
            end
            acn_pkg::ST_MUL_R:
            begin
                rf_reg    <= 51'(div_rem) * 51'(acn_pkg::NS_PER_SEC) + 51'(rate_eff >> 1);
                whole_reg <= 64'(plo_reg) + (64'(phi_reg) << 17);
            end
            acn_pkg::ST_SUM:
            begin
                offset_reg <= offset_sum;
            end
            acn_pkg::ST_EXPECT:
            begin
                exp_reg    <= exp_sum[62:0];
                newcum_reg <= cum_sum[62:0];
            end
            default:
            begin
                plo_reg <= plo_reg;
            end
        endcase
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if ((state_reg == acn_pkg::ST_IDLE) && avail)
        begin
            out_reg.norm  <= '0;
            out_reg.resid <= '0;
            if (sticky)
            begin
                out_reg.code     <= err_reg;
                out_reg.steps    <= steps_reg;
                out_reg.max_back <= back_reg;
                out_reg.max_res  <= wres_reg;
                out_reg.total    <= cum_reg;
            end
            else
            begin
                // An early error of a new stream reports the cleared state.
                out_reg.code     <= head.code;
                out_reg.steps    <= eff_first ? '0 : steps_reg;
                out_reg.max_back <= eff_first ? '0 : back_reg;
                out_reg.max_res  <= eff_first ? '0 : wres_reg;
                out_reg.total    <= eff_first ? '0 : cum_reg;
            end
        end
        else if (state_reg == acn_pkg::ST_FINISH)
        begin
            if (code_reg != acn_pkg::ERR_OK)
            begin
                out_reg.code     <= code_reg;
                out_reg.norm     <= '0;
                out_reg.resid    <= '0;
                out_reg.steps    <= steps_reg;
                out_reg.max_back <= back_reg;
                out_reg.max_res  <= wres_reg;
                out_reg.total    <= cum_reg;
            end
            else
            begin
                out_reg.code     <= acn_pkg::ERR_OK;
                out_reg.norm     <= exp_reg;
                out_reg.resid    <= ent_reg.ts - 64'(exp_reg);
                out_reg.steps    <= steps_new;
                out_reg.max_back <= back_new;
                out_reg.max_res  <= wres_new;
                out_reg.total    <= newcum_reg;
            end
        end
    end

    // Stream state, overflow code and result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_reg    <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            cum_reg       <= '0;
            steps_reg     <= '0;
            back_reg      <= '0;
            wres_reg      <= '0;
            err_reg       <= acn_pkg::ERR_OK;
            code_reg      <= acn_pkg::ERR_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                acn_pkg::ST_IDLE:
                begin
                    if (avail)
                    begin
                        if (sticky)
                        begin
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            if (eff_first)
                            begin
                                anchor_reg    <= '0;
                                prev_reg      <= '0;
                                have_prev_reg <= 1'b0;
                                cum_reg       <= '0;
                                steps_reg     <= '0;
                                back_reg      <= '0;
                                wres_reg      <= '0;
                            end
                            if (head.code != acn_pkg::ERR_OK)
                            begin
                                err_reg       <= head.code;
                                out_valid_reg <= 1'b1;
                            end
                            else if (eff_first)
                            begin
                                err_reg <= acn_pkg::ERR_OK;
                            end
                        end
                    end
                end
                acn_pkg::ST_DIV_Q:
                begin
                    if (div_done)
                    begin
                        code_reg <= q_over ? acn_pkg::ERR_OVF : acn_pkg::ERR_OK;
                    end
                end
                acn_pkg::ST_SUM:
                begin
                    if (offset_sum[63])
                    begin
                        code_reg <= acn_pkg::ERR_OVF;
                    end
                end
                acn_pkg::ST_EXPECT:
                begin
                    if (exp_ovf)
                    begin
                        code_reg <= acn_pkg::ERR_OVF;
                    end
                end
                acn_pkg::ST_FINISH:
                begin
                    out_valid_reg <= 1'b1;
                    if (code_reg != acn_pkg::ERR_OK)
                    begin
                        err_reg <= code_reg;
                    end
                    else
                    begin
                        if (first_reg)
                        begin
                            anchor_reg <= ts63;
                        end
                        prev_reg      <= ts63;
                        have_prev_reg <= 1'b1;
                        steps_reg     <= steps_new;
                        back_reg      <= back_new;
                        wres_reg      <= wres_new;
                        cum_reg       <= newcum_reg;
                    end
                end
                default:
                begin
                    code_reg <= code_reg;
                end
            endcase
        end
    end

endmodule

// File: design/audio_chunk_timestamp_normalizer.sv
// ----------------------------------------------------------------------------
// audio_chunk_timestamp_normalizer
// Rewrites audio chunk timestamps from an anchor and the running sample
// count, and reports residuals, diagnostics and sticky error codes.
//
//   channel   direction  handshake              payload
//   s_*       in         s_tvalid / s_tready    chunk timestamp and count
//   m_*       out        m_tvalid / m_tready    normalized time, diagnostics
//   cfg_*     in         cfg_valid / cfg_ready  register index and data
//
// A good chunk goes from the queue through the whole-second division on the
// shared bit-serial divider, the multiply states, a second division for the
// rounded fraction and the sum and finish states. A chunk rejected by a
// sticky error, a negative timestamp or a bad count has its result registered
// as it leaves the queue. Reset needs no clearing pass. The two-entry queue
// takes chunks until full while the back part works or the result waits.
// ----------------------------------------------------------------------------
module audio_chunk_timestamp_normalizer #(
    parameter int CHUNK_COUNT_BITS = 20
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // chunk_timestamp_ns [63:0], interleaved_count, zero fill
    input  logic [((64+CHUNK_COUNT_BITS+7)/8)*8-1:0] s_tdata,
    // first_chunk
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // normalized_ns [62:0], residual_ns [126:63], nonmonotonic_steps [158:127],
    // max_backward_step_ns [221:159], max_abs_residual_ns [284:222],
    // total_samples [347:285], zero fill [351:348]
    output logic [acn_pkg::OUT_W-1:0]              m_tdata,
    // error_code
    output logic [1:0]                             m_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic                                   cfg_index,
    input  logic [19:0]                            cfg_data
);

    logic [19:0] rate_reg;
    logic [1:0]  chan_reg;

    acn_pkg::q_entry_t front_entry;
    acn_pkg::q_entry_t q_head;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    acn_pkg::result_t  result;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= acn_pkg::RATE_RESET;
            chan_reg <= acn_pkg::CHAN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                acn_pkg::REG_SAMPLE_RATE:   rate_reg <= cfg_data;
                acn_pkg::REG_CHANNEL_COUNT: chan_reg <= cfg_data[1:0];
                default:                    rate_reg <= rate_reg;
            endcase
        end
    end

    acn_front #(
        .CHUNK_COUNT_BITS (CHUNK_COUNT_BITS)
    ) u_front (
        .first_chunk        (s_tuser),
        .chunk_timestamp_ns (s_tdata[63:0]),
        .interleaved_count  (s_tdata[64 +: CHUNK_COUNT_BITS]),
        .channel_count      (chan_reg),
        .entry              (front_entry)
    );

    acn_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_data (front_entry),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    acn_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .rate_cfg    (rate_reg),
        .head        (q_head),
        .empty       (q_empty),
        .pop         (q_pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (result)
    );

    // Pack the result transaction.
    assign m_tdata = {4'b0, result.total, result.max_res, result.max_back,
                      result.steps, result.resid, result.norm};
    assign m_tuser = result.code;

endmodule

// File: design/acn_checker.sv
// ----------------------------------------------------------------------------
// acn_checker
// Port-level checks of the normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module acn_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [acn_pkg::OUT_W-1:0] m_tdata,
    input logic [1:0]                m_tuser
);

    // A stalled result transaction holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An error result carries zero time fields.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != acn_pkg::ERR_OK) |-> (m_tdata[126:0] == '0))
        else $error("error result with nonzero time fields");

    // A good chunk always adds at least one frame.
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == acn_pkg::ERR_OK) |-> (m_tdata[347:285] != '0))
        else $error("good result with zero total samples");

    // The fill bits stay zero.
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[351:348] == '0))
        else $error("fill bits set");

endmodule

bind audio_chunk_timestamp_normalizer acn_checker u_acn_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/sv/tb_audio_chunk_timestamp_normalizer.sv
// ----------------------------------------------------------------------------
// tb_audio_chunk_timestamp_normalizer
// Self-checking testbench: drives audio chunks and register writes, predicts
// every result from a behavioral model of the normalizer and compares each
// result field by field.
// ----------------------------------------------------------------------------
module tb_audio_chunk_timestamp_normalizer;

    localparam int CNT_W   = 20;
    localparam int IN_W    = ((64 + CNT_W + 7) / 8) * 8;
    localparam int LIMIT   = 20000;
    localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NS1   = 64'd1000000000;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_W-1:0]           s_tdata;
    logic                      s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [acn_pkg::OUT_W-1:0] m_tdata;
    logic [1:0]                m_tuser;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic                      cfg_index;
    logic [19:0]               cfg_data;

    // Predicted results waiting for the block.
    typedef struct packed {
        logic [62:0] norm;
        logic [63:0] resid;
        logic [31:0] steps;
        logic [62:0] back;
        logic [62:0] res;
        logic [62:0] total;
        logic [1:0]  code;
    } chunk_result_t;

    chunk_result_t pending_results[$];

    // Predictor state.
    logic [19:0] rate_reg;
    logic [1:0]  chan_reg;
    logic [63:0] anchor, prev_ts, cum_frames, worst_back, worst_res;
    logic [31:0] steps;
    logic        have_prev;
    logic [1:0]  sticky;

    int  send_idle_pct;
    int  recv_idle_pct;
    int  quiet_cycles = 0;
    bit  failed = 1'b0;

    audio_chunk_timestamp_normalizer #(.CHUNK_COUNT_BITS(CNT_W)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clears the running stream state of the predictor.
    function automatic void clear_stream();
        anchor = '0;
        prev_ts = '0;
        have_prev = 1'b0;
        cum_frames = '0;
        steps = '0;
        worst_back = '0;
        worst_res = '0;
        sticky = acn_pkg::ERR_OK;
    endfunction

    // Converts frames to ns with round-half-up; returns 0 on overflow.
    function automatic bit frames_to_ns(input logic [63:0] frames,
                                        input logic [63:0] rate,
                                        output logic [63:0] ns);
        logic [63:0] q, r, whole, frac;
        logic [127:0] num;
        q = frames / rate;
        r = frames % rate;
        ns = '0;
        if (q > MAX63 / NS1)
            return 1'b0;
        whole = q * NS1;
        num = 128'(r) * 128'(NS1) + 128'(rate / 2);
        frac = 64'(num / 128'(rate));
        if (whole > MAX63 - frac)
            return 1'b0;
        ns = whole + frac;
        return 1'b1;
    endfunction

    // Computes the result of one chunk and advances the predictor state.
    function automatic chunk_result_t normalize_chunk(input logic first_in,
                                                      input logic [63:0] ts,
                                                      input logic [19:0] cnt);
        chunk_result_t res;
        logic [63:0] rate, frames, offset, expected, newcum, base, absres;
        logic [63:0] n_back;
        logic [31:0] n_steps;
        logic [1:0]  code;
        bit          first;
        first = first_in;
        rate = (rate_reg == 0) ? 64'd1 : 64'(rate_reg);
        code = acn_pkg::ERR_OK;
        frames = '0;
        offset = '0;
        expected = '0;
        newcum = '0;
        if (!first && sticky != acn_pkg::ERR_OK)
        begin
            res = '{norm: '0, resid: '0, steps: steps, back: worst_back[62:0],
                    res: worst_res[62:0], total: cum_frames[62:0], code: sticky};
            return res;
        end
        if (first || !have_prev)
        begin
            clear_stream();
            first = 1'b1;
        end
        if (ts[63])
            code = acn_pkg::ERR_NEG;
        else if (cnt == 0 || (chan_reg != 2'd1 && chan_reg != 2'd2) ||
                 (cnt % chan_reg) != 0)
            code = acn_pkg::ERR_COUNT;
        if (code == acn_pkg::ERR_OK)
        begin
            frames = 64'(cnt / chan_reg);
            if (!frames_to_ns(cum_frames, rate, offset))
                code = acn_pkg::ERR_OVF;
        end
        if (code == acn_pkg::ERR_OK)
        begin
            base = first ? ts : anchor;
            if (base > MAX63 - offset)
                code = acn_pkg::ERR_OVF;
            else
                expected = base + offset;
        end
        if (code == acn_pkg::ERR_OK)
        begin
            if (cum_frames > MAX63 - frames)
                code = acn_pkg::ERR_OVF;
            else
                newcum = cum_frames + frames;
        end
        if (code != acn_pkg::ERR_OK)
        begin
            sticky = code;
            res = '{norm: '0, resid: '0, steps: steps, back: worst_back[62:0],
                    res: worst_res[62:0], total: cum_frames[62:0], code: code};
            return res;
        end
        n_steps = steps;
        n_back = worst_back;
        if (!first)
        begin
            if (ts <= prev_ts && n_steps != acn_pkg::STEP_MAX)
                n_steps++;
            if (ts < prev_ts && prev_ts - ts > n_back)
                n_back = prev_ts - ts;
        end
        absres = (ts >= expected) ? ts - expected : expected - ts;
        if (first)
            anchor = ts;
        prev_ts = ts;
        have_prev = 1'b1;
        steps = n_steps;
        worst_back = n_back;
        if (absres > worst_res)
            worst_res = absres;
        cum_frames = newcum;
        res = '{norm: expected[62:0], resid: ts - expected, steps: steps,
                back: worst_back[62:0], res: worst_res[62:0],
                total: cum_frames[62:0], code: acn_pkg::ERR_OK};
        return res;
    endfunction

    // Sends one chunk and records its predicted result.
    task automatic send_chunk(input logic first, input logic [63:0] ts,
                              input logic [19:0] cnt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        s_tdata  <= IN_W'({cnt, ts});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.insert(pending_results.size(), normalize_chunk(first, ts, cnt));
    endtask

    // Waits until every expected result has arrived, then lets the block settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
    endtask

    // Writes one register while the block is idle.
    task automatic write_reg(input logic idx, input logic [19:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == acn_pkg::REG_SAMPLE_RATE)
            rate_reg = val;
        else
            chan_reg = val[1:0];
    endtask

    // Random timestamp biased toward realistic positive values.
    function automatic logic [63:0] rand_ts();
        case ($urandom_range(9))
            0: return {$urandom, $urandom};
            1: return {1'b0, 31'($urandom), $urandom};
            2: return MAX63 - 64'($urandom_range(1000000));
            default: return 64'($urandom_range(32'h7FFF_FFFF)) * 64'd16;
        endcase
    endfunction

    // Random count, mostly aligned and nonzero.
    function automatic logic [19:0] rand_cnt();
        case ($urandom_range(9))
            0: return 20'($urandom);
            1: return 20'($urandom_range(3));
            2: return 20'hFFFFE;
            default: return 20'($urandom_range(2048)) * 20'd2 + 20'd2;
        endcase
    endfunction

    // Extremes of the fields and each special case.
    task automatic test_directed();
        send_chunk(1'b0, 64'd1000, 20'd960);
        send_chunk(1'b0, 64'd21000000, 20'd960);
        send_chunk(1'b0, 64'd10000000, 20'd960);
        send_chunk(1'b0, 64'd10000000, 20'd960);
        send_chunk(1'b0, 64'd5, 20'hFFFFE);
        send_chunk(1'b0, 64'd5, 20'd3);
        send_chunk(1'b0, 64'd99, 20'd4);
        send_chunk(1'b1, 64'h8000_0000_0000_0000, 20'd2);
        send_chunk(1'b0, 64'd0, 20'd2);
        send_chunk(1'b1, 64'd0, 20'd0);
        send_chunk(1'b1, MAX63, 20'd2);
        send_chunk(1'b0, MAX63, 20'd2);
        send_chunk(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 20'hFFFFF);
        send_chunk(1'b1, 64'd0, 20'hFFFFE);
        send_chunk(1'b0, 64'd1, 20'hFFFFE);
        send_chunk(1'b0, 64'd0, 20'd2);
        write_reg(acn_pkg::REG_CHANNEL_COUNT, 20'd1);
        write_reg(acn_pkg::REG_SAMPLE_RATE, 20'd0);
        send_chunk(1'b1, 64'd7, 20'hFFFFF);
        send_chunk(1'b0, 64'd3, 20'd1);
        send_chunk(1'b0, 64'd3, 20'd1);
        write_reg(acn_pkg::REG_CHANNEL_COUNT, 20'd3);
        send_chunk(1'b1, 64'd7, 20'd3);
        write_reg(acn_pkg::REG_CHANNEL_COUNT, 20'd0);
        send_chunk(1'b1, 64'd7, 20'd3);
    endtask

    // Random streams under one register setting.
    task automatic test_random_phase(input logic [19:0] rate,
                                     input logic [1:0] chan, input int n);
        logic [63:0] ts;
        logic [19:0] cnt;
        write_reg(acn_pkg::REG_SAMPLE_RATE, rate);
        write_reg(acn_pkg::REG_CHANNEL_COUNT, 20'(chan));
        ts = 64'd1000;
        for (int i = 0; i < n; i++)
        begin
            cnt = rand_cnt();
            if ($urandom_range(99) < 8)
                send_chunk(1'b1, rand_ts(), cnt);
            else if ($urandom_range(99) < 80)
            begin
                // Well-formed progression with a little jitter.
                ts = ts + 64'($urandom_range(30000000)) - 64'd2000000;
                send_chunk(1'b0, ts, cnt);
            end
            else
                send_chunk($urandom_range(1), rand_ts(), cnt);
        end
    endtask

    // Repeated timestamps raise the non-monotonic step count on each chunk.
    task automatic test_step_saturation();
        write_reg(acn_pkg::REG_SAMPLE_RATE, 20'd48000);
        write_reg(acn_pkg::REG_CHANNEL_COUNT, 20'd2);
        send_chunk(1'b1, 64'd500, 20'd2);
        wait_idle();
        for (int i = 0; i < 4; i++)
            send_chunk(1'b0, 64'd500, 20'd2);
    endtask

    // Drives the receiver side and checks each result transaction.
    always @(posedge clk)
    begin
        chunk_result_t exp_r;
        chunk_result_t act;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                act.norm  = m_tdata[62:0];
                act.resid = m_tdata[126:63];
                act.steps = m_tdata[158:127];
                act.back  = m_tdata[221:159];
                act.res   = m_tdata[284:222];
                act.total = m_tdata[347:285];
                act.code  = m_tuser;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result transaction", $realtime);
                    failed = 1'b1;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (exp_r != act)
                    begin
                        $display("%0t: mismatch expected norm=%0d resid=%0d steps=%0d",
                                 $realtime, exp_r.norm, $signed(exp_r.resid),
                                 exp_r.steps);
                        $display("    back=%0d res=%0d total=%0d code=%0d",
                                 exp_r.back, exp_r.res, exp_r.total, exp_r.code);
                        $display("  actual norm=%0d resid=%0d steps=%0d",
                                 act.norm, $signed(act.resid), act.steps);
                        $display("    back=%0d res=%0d total=%0d code=%0d",
                                 act.back, act.res, act.total, act.code);
                        failed = 1'b1;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready) || pending_results.size() == 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = acn_pkg::REG_SAMPLE_RATE;
        cfg_data = '0;
        send_idle_pct = 23;
        recv_idle_pct = 55;
        rate_reg = acn_pkg::RATE_RESET;
        chan_reg = acn_pkg::CHAN_RESET;
        clear_stream();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(20'd48000, 2'd2, 200);
        test_random_phase(20'hFFFFF, 2'd1, 100);
        send_idle_pct = 55;
        recv_idle_pct = 23;
        test_random_phase(20'd1, 2'd2, 100);
        test_random_phase(20'd44100, 2'd1, 200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_phase(20'd7, 2'd2, 150);
        test_random_phase(20'd96000, 2'd2, 170);
        test_step_saturation();

        wait_idle();
        if (!failed)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
